// ===== hdl/bqc_pkg.sv =====
// Package for the biquad cascade filter.
// Fixed-point types, function codes and section step codes; no dependencies.
`timescale 1ns / 1ps

package bqc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int PROD_W   = 40;
    localparam int DELAY_W  = 40;
    localparam int ACC_W    = 42;
    localparam int COEFS_PER_SECTION = 5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [DELAY_W-1:0]  t_delay;
    typedef logic signed [ACC_W-1:0]    t_acc;

    localparam logic [1:0] FUNC_FILTER = 2'd0;
    localparam logic [1:0] FUNC_COEF   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [2:0] SLOT_A2 = 3'd4;

    // step codes within one section
    localparam logic [2:0] STEP_ISSUE  = 3'd0;
    localparam logic [2:0] STEP_MUL_B0 = 3'd1;
    localparam logic [2:0] STEP_ADD_D0 = 3'd2;
    localparam logic [2:0] STEP_OUT_Y  = 3'd3;
    localparam logic [2:0] STEP_MUL_A1 = 3'd4;
    localparam logic [2:0] STEP_SUB_A1 = 3'd5;
    localparam logic [2:0] STEP_SUB_A2 = 3'd6;
    localparam logic [2:0] STEP_WRITE  = 3'd7;

    typedef struct packed {
        logic       run;
        logic       load;
        logic [2:0] step;
    } t_dp_ctrl;

endpackage

// ===== hdl/bqc_coef_store.sv =====
// Coefficient memory with per-entry valid bits; unwritten entries read as zero.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_coef_store
    import bqc_pkg::*;
#(
    parameter int DEPTH = 20,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_coef         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_coef         o_rdata
);

    t_coef            r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_coef            r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ===== hdl/bqc_delay_store.sv =====
// Delay memory, one row {d0, d1} per section, valid bit per row.
// A clear drops all valid bits. Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_delay_store
    import bqc_pkg::*;
#(
    parameter int ROWS = 4,
    parameter int AW   = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_delay        i_d0,
    input  t_delay        i_d1,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_delay        o_d0,
    output t_delay        o_d1
);

    logic [2*DELAY_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]      r_vld;
    logic [2*DELAY_W-1:0] r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_d0, i_d1};
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_clear) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_d0 = r_rvld ? t_delay'(r_rdata[2*DELAY_W-1:DELAY_W]) : '0;
    assign o_d1 = r_rvld ? t_delay'(r_rdata[DELAY_W-1:0]) : '0;

endmodule

// ===== hdl/bqc_datapath.sv =====
// Shared multiply-accumulate unit of one biquad section, driven step by step.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_datapath
    import bqc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_ctrl i_ctrl,
    input  t_sample  i_sample,
    input  t_coef    i_coef,
    input  t_delay   i_d0,
    input  t_delay   i_d1,
    output t_sample  o_x,
    output logic     o_sat,
    output t_delay   o_d0,
    output t_delay   o_d1
);

    localparam t_acc ROUND_HALF = t_acc'(1) <<< 20;
    localparam t_acc Y_MAX      = 42'sd32767;
    localparam t_acc Y_MIN      = -42'sd32768;
    localparam t_acc D_MAX      = 42'sd549755813887;
    localparam t_acc D_MIN      = -42'sd549755813888;

    t_sample r_x;
    t_sample r_y;
    t_prod   r_prod;
    t_acc    r_acc0;
    t_acc    r_acc1;
    logic    r_sat;

    t_sample mul_op;
    t_prod   mul;
    t_acc    rnd;
    t_acc    y_wide;
    t_sample y_sat;
    logic    y_clip;

    function automatic t_delay sat_delay(input t_acc v);
        if (v > D_MAX) begin
            sat_delay = t_delay'(D_MAX);
        end else if (v < D_MIN) begin
            sat_delay = t_delay'(D_MIN);
        end else begin
            sat_delay = t_delay'(v);
        end
    endfunction

    assign mul_op = (i_ctrl.step == STEP_MUL_A1 || i_ctrl.step == STEP_SUB_A1) ? r_y : r_x;
    assign mul    = i_coef * mul_op;

    assign rnd    = r_acc0 + ROUND_HALF;
    assign y_wide = rnd >>> 21;

    always_comb begin
        y_clip = 1'b1;
        if (y_wide > Y_MAX) begin
            y_sat = t_sample'(Y_MAX);
        end else if (y_wide < Y_MIN) begin
            y_sat = t_sample'(Y_MIN);
        end else begin
            y_sat  = t_sample'(y_wide);
            y_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul;
        if (i_ctrl.load) begin
            r_x <= i_sample;
        end else if (i_ctrl.run) begin
            case (i_ctrl.step)
                STEP_ADD_D0: begin
                    r_acc0 <= t_acc'(r_prod) + t_acc'(i_d0);
                end
                STEP_OUT_Y: begin
                    r_y    <= y_sat;
                    r_acc0 <= t_acc'(r_prod) + t_acc'(i_d1);
                end
                STEP_MUL_A1: begin
                    r_acc1 <= t_acc'(r_prod);
                end
                STEP_SUB_A1: begin
                    r_acc0 <= r_acc0 - t_acc'(r_prod);
                end
                STEP_SUB_A2: begin
                    r_acc1 <= r_acc1 - t_acc'(r_prod);
                end
                STEP_WRITE: begin
                    r_x <= r_y;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_ctrl.load) begin
            r_sat <= 1'b0;
        end else if (i_ctrl.run && i_ctrl.step == STEP_OUT_Y && y_clip) begin
            r_sat <= 1'b1;
        end
    end

    assign o_x   = r_x;
    assign o_sat = r_sat;
    assign o_d0  = sat_delay(r_acc0);
    assign o_d1  = sat_delay(r_acc1);

endmodule

// ===== hdl/biquad_cascade_filter.sv =====
// Biquad cascade, direct form II transposed, one shared 24x16 multiplier.
// A sample item holds o_stall high, so no new item is accepted, from its acceptance
// until its result is registered; it runs n = min(active_sections, SECTIONS) sections.
// Five products per section in 8 steps; a stalled earlier result holds it in the done state.
// Coefficient and clear items keep the state idle. Synchronous reset clears the valid
// bits of both stores (entries read as zero) and active_sections; no clearing pass.
`timescale 1ns / 1ps

module biquad_cascade_filter
    import bqc_pkg::*;
#(
    parameter int SECTIONS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_func,
    input  logic signed [15:0]  i_sample_in,
    input  logic                i_block_end,
    input  logic [1:0]          i_coef_section,
    input  logic [2:0]          i_coef_slot,
    input  logic signed [23:0]  i_coef_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_sample_out,
    output logic                o_saturated,
    output logic                o_block_end_out
);

    localparam int CDEPTH = COEFS_PER_SECTION * SECTIONS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int SW     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    r_state;
    logic [2:0]    r_step;
    logic [SW-1:0] r_sec;
    logic [3:0]    r_left;
    logic [CAW-1:0] r_cbase;
    logic [2:0]    r_active;
    logic          r_bend;
    logic          r_oval;
    t_sample       r_out;
    logic          r_osat;
    logic          r_obend;

    logic          accept;
    logic [3:0]    sec_count;
    logic          coef_ok;
    logic [5:0]    waddr_wide;
    logic          out_free;
    t_dp_ctrl      ctrl;
    t_coef         coef;
    t_delay        d0_rd;
    t_delay        d1_rd;
    t_delay        d0_wr;
    t_delay        d1_wr;
    t_sample       x;
    logic          sat;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_oval || !i_stall;

    assign sec_count  = ({1'b0, r_active} > 4'(SECTIONS)) ? 4'(SECTIONS) : {1'b0, r_active};
    assign coef_ok    = (i_coef_slot <= SLOT_A2) && ({2'b00, i_coef_section} < 4'(SECTIONS));
    assign waddr_wide = {2'b00, i_coef_section, 2'b00} + {4'b0000, i_coef_section}
                      + {3'b000, i_coef_slot};

    assign ctrl.run  = (r_state == S_RUN);
    assign ctrl.load = accept && (i_func == FUNC_FILTER);
    assign ctrl.step = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 3'd0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_ISSUE;
            r_sec   <= '0;
            r_left  <= 4'd0;
            r_cbase <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_func == FUNC_FILTER) begin
                        r_bend  <= i_block_end;
                        r_step  <= STEP_ISSUE;
                        r_sec   <= '0;
                        r_cbase <= '0;
                        r_left  <= sec_count;
                        r_state <= (sec_count == 4'd0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == STEP_WRITE) begin
                        r_left  <= r_left - 4'd1;
                        r_sec   <= r_sec + SW'(1);
                        r_cbase <= r_cbase + CAW'(COEFS_PER_SECTION);
                        if (r_left == 4'd1) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= x;
                        r_osat  <= sat;
                        r_obend <= r_bend;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bqc_coef_store #(
        .DEPTH (CDEPTH),
        .AW    (CAW)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && i_func == FUNC_COEF && coef_ok),
        .i_waddr (CAW'(waddr_wide)),
        .i_wdata (i_coef_value),
        .i_re    (ctrl.run && r_step <= STEP_MUL_A1),
        .i_raddr (r_cbase + CAW'(r_step)),
        .o_rdata (coef)
    );

    bqc_delay_store #(
        .ROWS (SECTIONS),
        .AW   (SW)
    ) u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept && i_func == FUNC_CLEAR),
        .i_we    (ctrl.run && r_step == STEP_WRITE),
        .i_waddr (r_sec),
        .i_d0    (d0_wr),
        .i_d1    (d1_wr),
        .i_re    (ctrl.run && r_step == STEP_ISSUE),
        .i_raddr (r_sec),
        .o_d0    (d0_rd),
        .o_d1    (d1_rd)
    );

    bqc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_sample (i_sample_in),
        .i_coef   (coef),
        .i_d0     (d0_rd),
        .i_d1     (d1_rd),
        .o_x      (x),
        .o_sat    (sat),
        .o_d0     (d0_wr),
        .o_d1     (d1_wr)
    );

    assign o_valid         = r_oval;
    assign o_sample_out    = r_out;
    assign o_saturated     = r_osat;
    assign o_block_end_out = r_obend;

`ifndef SYNTHESIS
    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> (r_left != 4'd0 && r_left <= 4'(SECTIONS)))
        else $error("section count out of range while running");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_FILTER && sec_count == 4'd0) |=> r_state == S_DONE)
        else $error("bypass sample did not go straight to result");

    a_last_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == STEP_WRITE && r_left == 4'd1) |=> r_state == S_DONE)
        else $error("cascade did not finish after last section");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !ctrl.load)
        else $error("sample loaded while busy");
`endif

endmodule
